/* design/hslc_pkg.sv */
// ----------------------------------------------------------------------------
// hslc_pkg
// Shared widths, constants and stage types of the HSL to RGB converter.
// ----------------------------------------------------------------------------
package hslc_pkg;

	localparam int HueW   = 9;
	localparam int PctW   = 7;
	localparam int ByteW  = 8;
	localparam int NumCh  = 3;
	localparam int FracW  = 14;	// p, q, d in units of 1/10000
	localparam int ArgW   = 11;	// hue argument in units of 1/1080 turn
	localparam int RampW  = 8;	// ramp position 0..180
	localparam int NumW   = 21;	// ramp numerator over 1800000
	localparam int RecipW = 26;
	localparam int RecipShift = 38;
	localparam int ProdW  = RecipShift + ByteW + 1;

	localparam int HueMax  = 360;
	localparam int PctMax  = 100;
	localparam int LitHalf = 50;
	localparam int Third   = 360;
	localparam int Turn    = 1080;
	localparam int Seg1    = 180;
	localparam int Seg2    = 540;
	localparam int Seg3    = 720;
	localparam int ByteMax = 255;

	// floor(n*17/120000) == (n*RecipMul) >> RecipShift for n < 2^21
	localparam logic [RecipW-1:0] RecipMul =
		RecipW'(((64'd17 << RecipShift) + 64'd119999) / 64'd120000);

	typedef struct packed {
		logic [FracW-1:0]                p;
		logic [FracW-1:0]                d;
		logic [NumCh-1:0][RampW-1:0]     x;
	} hslc_s1_t;

	typedef logic [NumCh-1:0][NumW-1:0]  hslc_num_t;
	typedef logic [NumCh-1:0][ByteW-1:0] hslc_rgb_t;

	function automatic logic [RampW-1:0] ramp_x(input logic [ArgW-1:0] t);
		logic [RampW-1:0] r;
		if (t < ArgW'(Seg1)) begin
			r = t[RampW-1:0];
		end else if (t < ArgW'(Seg2)) begin
			r = RampW'(Seg1);
		end else if (t < ArgW'(Seg3)) begin
			r = RampW'(ArgW'(Seg3) - t);
		end else begin
			r = '0;
		end
		return r;
	endfunction

endpackage

/* design/hsl_to_rgb_converter_core.sv */
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_core: HSL pixel to 8-bit RGB, four register stages.
// One pixel per cycle while the output is not back-pressured.
// Each stage holds under back-pressure; bubbles are squeezed out.
// arst_n clears all valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,	// hue_deg[8:0], sat_pct[15:9], light_pct[22:16], pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata	// red[7:0], green[15:8], blue[23:16]
);
	import hslc_pkg::*;

	logic      v_s1;
	logic      v_s2;
	logic      v_s3;
	logic      rdy1;
	logic      rdy2;
	logic      rdy3;
	logic      rdy4;
	hslc_s1_t  stage_s1;
	hslc_num_t num_s2;
	hslc_rgb_t rgb_s4;

	assign rdy4 = !m_axis_tvalid || m_axis_tready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				m_axis_tvalid <= v_s3;
			end
		end
	end

	hslc_front u_front (
		.clk       (clk),
		.en        (rdy1 && s_axis_tvalid),
		.hue_deg   (s_axis_tdata[8:0]),
		.sat_pct   (s_axis_tdata[15:9]),
		.light_pct (s_axis_tdata[22:16]),
		.stage_s1  (stage_s1)
	);

	hslc_ramp u_ramp (
		.clk      (clk),
		.en       (rdy2 && v_s1),
		.stage_s1 (stage_s1),
		.num_s2   (num_s2)
	);

	hslc_quant u_quant (
		.clk    (clk),
		.en3    (rdy3 && v_s2),
		.en4    (rdy4 && v_s3),
		.num_s2 (num_s2),
		.rgb_s4 (rgb_s4)
	);

	assign m_axis_tdata = {rgb_s4[2], rgb_s4[1], rgb_s4[0]};

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted transaction not captured in stage 1");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !rdy3 |=> v_s3)
		else $error("stage 3 dropped a transaction under stall");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output stage is empty");

endmodule

/* design/hslc_front.sv */
// ----------------------------------------------------------------------------
// hslc_front
// Stage 1: input clamping, p/q construction, hue argument wrapping and ramp positions.
// ----------------------------------------------------------------------------
module hslc_front (
	input  logic                      clk,
	input  logic                      en,
	input  logic [hslc_pkg::HueW-1:0] hue_deg,
	input  logic [hslc_pkg::PctW-1:0] sat_pct,
	input  logic [hslc_pkg::PctW-1:0] light_pct,
	output hslc_pkg::hslc_s1_t        stage_s1
);
	import hslc_pkg::*;

	logic [HueW-1:0]  hue;
	logic [PctW-1:0]  sat;
	logic [PctW-1:0]  lit;
	logic [ArgW-1:0]  h3;
	logic [ArgW-1:0]  t_r;
	logic [ArgW-1:0]  t_b;
	logic [FracW-1:0] lsp;
	logic [14:0]      lit100;
	logic [14:0]      sat100;
	logic [14:0]      q15;
	logic [14:0]      p15;
	hslc_s1_t         nxt;

	always_comb begin
		hue = (hue_deg > HueW'(HueMax)) ? HueW'(HueMax) : hue_deg;
		sat = (sat_pct > PctW'(PctMax)) ? PctW'(PctMax) : sat_pct;
		lit = (light_pct > PctW'(PctMax)) ? PctW'(PctMax) : light_pct;

		h3  = ArgW'({hue, 1'b0}) + ArgW'(hue);
		t_r = h3 + ArgW'(Third);
		if (t_r > ArgW'(Turn)) begin
			t_r = t_r - ArgW'(Turn);
		end
		t_b = (h3 < ArgW'(Third)) ? h3 + ArgW'(Turn - Third) : h3 - ArgW'(Third);

		lsp    = FracW'(FracW'(lit) * FracW'(sat));
		lit100 = 15'(15'(lit) * 15'd100);
		sat100 = 15'(15'(sat) * 15'd100);
		q15    = (lit < PctW'(LitHalf)) ? lit100 + 15'(lsp) : lit100 + sat100 - 15'(lsp);
		p15    = 15'(15'(lit) * 15'd200) - q15;

		nxt.p    = p15[FracW-1:0];
		nxt.d    = q15[FracW-1:0] - p15[FracW-1:0];
		nxt.x[0] = ramp_x(t_r);
		nxt.x[1] = ramp_x(h3);
		nxt.x[2] = ramp_x(t_b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s1 <= nxt;
		end
	end

endmodule

/* design/hslc_ramp.sv */
// ----------------------------------------------------------------------------
// hslc_ramp
// Stage 2: ramp numerator p*180 + (q-p)*x for each channel.
// ----------------------------------------------------------------------------
module hslc_ramp (
	input  logic                clk,
	input  logic                en,
	input  hslc_pkg::hslc_s1_t  stage_s1,
	output hslc_pkg::hslc_num_t num_s2
);
	import hslc_pkg::*;

	hslc_num_t nxt;

	always_comb begin
		for (int c = 0; c < NumCh; c++) begin
			nxt[c] = NumW'(NumW'(stage_s1.p) * NumW'(Seg1))
			       + NumW'(NumW'(stage_s1.d) * NumW'(stage_s1.x[c]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= nxt;
		end
	end

endmodule

/* design/hslc_quant.sv */
// ----------------------------------------------------------------------------
// hslc_quant
// Stages 3 and 4: scale by 255/1800000 via reciprocal multiply, truncate, saturate at 255.
// ----------------------------------------------------------------------------
module hslc_quant (
	input  logic                clk,
	input  logic                en3,
	input  logic                en4,
	input  hslc_pkg::hslc_num_t num_s2,
	output hslc_pkg::hslc_rgb_t rgb_s4
);
	import hslc_pkg::*;

	logic [NumCh-1:0][ProdW-1:0] prod_s3;
	hslc_rgb_t                   nxt;

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int c = 0; c < NumCh; c++) begin
				prod_s3[c] <= ProdW'(num_s2[c]) * ProdW'(RecipMul);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NumCh; c++) begin
			if (prod_s3[c][ProdW-1:RecipShift] > (ProdW - RecipShift)'(ByteMax)) begin
				nxt[c] = ByteW'(ByteMax);
			end else begin
				nxt[c] = prod_s3[c][RecipShift +: ByteW];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			rgb_s4 <= nxt;
		end
	end

endmodule
